### sv/fkpc_pkg.sv
// shared types, constants and code tables for the four-key press classifier
package fkpc_pkg;

	localparam int NUM_KEYS        = 4;
	localparam int MAX_EVENTS      = 4;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int APB_ADDR_W      = 5;
	localparam int APB_DATA_W      = 32;

	localparam logic [6:0] PARK_COUNT = 7'd100;

	// reset values of the configuration registers
	localparam logic       SOUND_ENABLE_RST = 1'b1;
	localparam logic [7:0] BEEP_TICKS_RST   = 8'd2;
	localparam logic [4:0] CONFIRM_RST      = 5'd3;
	localparam logic [6:0] LONG_EF_RST      = 7'd50;
	localparam logic [6:0] LONG_PWR_RST     = 7'd30;

	// register indexes (byte address is 4 * index)
	typedef enum logic [2:0] {
		REG_SOUND_ENABLE = 3'd0,
		REG_BEEP_TICKS   = 3'd1,
		REG_CONFIRM      = 3'd2,
		REG_LONG_EF      = 3'd3,
		REG_LONG_PWR     = 3'd4
	} reg_idx_t;

	// key positions in scan order
	localparam logic [1:0] KEY_ENT   = 2'd0;
	localparam logic [1:0] KEY_POWER = 2'd1;
	localparam logic [1:0] KEY_F1    = 2'd2;
	localparam logic [1:0] KEY_F2    = 2'd3;

	typedef logic [3:0] event_code_t;

	localparam event_code_t EV_NONE      = 4'd0;
	localparam event_code_t EV_ENTER     = 4'd1;
	localparam event_code_t EV_PWR_LONG  = 4'd2;
	localparam event_code_t EV_PWR_SHORT = 4'd3;
	localparam event_code_t EV_F1_DOWN   = 4'd4;
	localparam event_code_t EV_F1_LONG   = 4'd5;
	localparam event_code_t EV_F1_UP     = 4'd6;
	localparam event_code_t EV_F2_DOWN   = 4'd7;
	localparam event_code_t EV_F2_LONG   = 4'd8;
	localparam event_code_t EV_F2_UP     = 4'd9;

	typedef struct packed {
		logic       sound_enable;
		logic [7:0] beep_ticks;
		logic [4:0] confirm_ticks;
		logic [6:0] long_ticks_enter_fkeys;
		logic [6:0] long_ticks_power;
	} cfg_t;

	// one classified tick, waiting to be sent out as 1 to 4 items
	typedef struct packed {
		event_code_t [MAX_EVENTS-1:0] codes;
		logic [1:0]                   last_idx;
		logic                         beep_on;
		logic                         wake_screen;
		logic                         key_activity;
	} q_entry_t;

	function automatic event_code_t code_down(input logic [1:0] key);
		event_code_t c;
		unique case (key)
			KEY_F1:  c = EV_F1_DOWN;
			KEY_F2:  c = EV_F2_DOWN;
			default: c = EV_NONE;
		endcase
		return c;
	endfunction

	function automatic event_code_t code_long(input logic [1:0] key);
		event_code_t c;
		unique case (key)
			KEY_POWER: c = EV_PWR_LONG;
			KEY_F1:    c = EV_F1_LONG;
			KEY_F2:    c = EV_F2_LONG;
			default:   c = EV_NONE;
		endcase
		return c;
	endfunction

	function automatic event_code_t code_up(input logic [1:0] key);
		event_code_t c;
		unique case (key)
			KEY_ENT:   c = EV_ENTER;
			KEY_POWER: c = EV_PWR_SHORT;
			KEY_F1:    c = EV_F1_UP;
			default:   c = EV_F2_UP;
		endcase
		return c;
	endfunction

endpackage

### sv/fkpc_if.sv
// item channel interfaces: scan ticks in, key events out
interface fkpc_tick_if;
	logic valid;
	logic ready;
	logic enter_down;
	logic power_down;
	logic f1_down;
	logic f2_down;
	logic screen_asleep;

	modport source (output valid, enter_down, power_down, f1_down, f2_down, screen_asleep,
		input ready);
	modport sink (input valid, enter_down, power_down, f1_down, f2_down, screen_asleep,
		output ready);
endinterface

interface fkpc_event_if import fkpc_pkg::*; ;
	logic        valid;
	logic        ready;
	event_code_t event_code;
	logic        beep_on;
	logic        wake_screen;
	logic        key_activity;
	logic        last;

	modport source (output valid, event_code, beep_on, wake_screen, key_activity, last,
		input ready);
	modport sink (input valid, event_code, beep_on, wake_screen, key_activity, last,
		output ready);
endinterface

### sv/four_key_press_classifier.sv
// top level of the four-key press classifier: register port, front, queue and back
//
// Each input item is one scan tick with the four key levels (enter, power, F1, F2)
// and the screen-asleep flag. The front part updates the per-key hold counters and
// the beeper in the cycle the tick is accepted and can take a new tick every cycle
// while the queue has room. The back part sends one result item per cycle while
// the event channel is ready, one for each event of the tick in scan order (one
// item with event code none if the tick made no event), so a tick gives 1 to 4
// items; the output channel sets the sustained rate. The queue between the two
// parts (QUEUE_DEPTH ticks) lets the scanner keep feeding ticks while a slow
// consumer stalls the event channel. Configuration registers sit at byte
// address 4*index on the register port: sound enable, beep length, confirm count,
// long-press count for enter and F keys, long-press count for power. They should
// be written only while no tick is in flight.
module four_key_press_classifier import fkpc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fkpc_tick_if.sink             tick,
	fkpc_event_if.source          evt,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t     cfg_q;
	q_entry_t push_entry, head_entry;
	logic     push, pop, q_full, q_valid;
	logic     cfg_wr;
	reg_idx_t reg_idx;

	// register port: zero wait states, write lands on the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_enable           <= SOUND_ENABLE_RST;
			cfg_q.beep_ticks             <= BEEP_TICKS_RST;
			cfg_q.confirm_ticks          <= CONFIRM_RST;
			cfg_q.long_ticks_enter_fkeys <= LONG_EF_RST;
			cfg_q.long_ticks_power       <= LONG_PWR_RST;
		end else if (cfg_wr) begin
			// addresses past the last register are ignored
			unique case (reg_idx)
				REG_SOUND_ENABLE: cfg_q.sound_enable           <= pwdata[0];
				REG_BEEP_TICKS:   cfg_q.beep_ticks             <= pwdata[7:0];
				REG_CONFIRM:      cfg_q.confirm_ticks          <= pwdata[4:0];
				REG_LONG_EF:      cfg_q.long_ticks_enter_fkeys <= pwdata[6:0];
				REG_LONG_PWR:     cfg_q.long_ticks_power       <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// read back, zero-extended
	always_comb begin
		unique case (reg_idx)
			REG_SOUND_ENABLE: prdata = APB_DATA_W'(cfg_q.sound_enable);
			REG_BEEP_TICKS:   prdata = APB_DATA_W'(cfg_q.beep_ticks);
			REG_CONFIRM:      prdata = APB_DATA_W'(cfg_q.confirm_ticks);
			REG_LONG_EF:      prdata = APB_DATA_W'(cfg_q.long_ticks_enter_fkeys);
			REG_LONG_PWR:     prdata = APB_DATA_W'(cfg_q.long_ticks_power);
			default:          prdata = '0;
		endcase
	end

	// front: key counters, wake handling, beeper, event packing
	fkpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// classified ticks waiting for the output side
	fkpc_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(q_entry_t))
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_entry),
		.pop       (pop),
		.rdata     (head_entry),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// back: one item per event (a single none item for a tick without events), last marks the end of the tick
	fkpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.entry   (head_entry),
		.q_valid (q_valid),
		.pop     (pop),
		.evt     (evt)
	);

endmodule

### sv/fkpc_front.sv
// front part: takes scan ticks, runs the key counters and the beeper, packs events
module fkpc_front import fkpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fkpc_tick_if.sink  tick,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       push,
	output q_entry_t   entry
);

	logic [NUM_KEYS-1:0][6:0] hold_q, hold_d;
	logic [NUM_KEYS-1:0]      armed_q, armed_d;
	logic                     beep_active_q, beep_active_d;
	logic [7:0]               beep_elapsed_q, beep_elapsed_d;

	logic [NUM_KEYS-1:0] held;
	event_code_t [NUM_KEYS-1:0] ev;
	logic        asleep, woke, activity, start;
	logic [7:0]  nxt;
	logic [6:0]  lim;
	logic [2:0]  nev;
	logic        act0;
	logic [7:0]  el0;
	logic [8:0]  bnext;

	assign held = {tick.f2_down, tick.f1_down, tick.power_down, tick.enter_down};

	assign tick.ready = !q_full;
	assign push       = tick.valid && !q_full;

	always_comb begin
		asleep   = tick.screen_asleep;
		woke     = 1'b0;
		activity = 1'b0;
		start    = 1'b0;
		hold_d   = hold_q;
		armed_d  = armed_q;
		nxt      = '0;
		lim      = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			ev[i] = EV_NONE;
			lim   = (i == int'(KEY_POWER)) ? cfg.long_ticks_power : cfg.long_ticks_enter_fkeys;
			nxt   = {1'b0, hold_q[i]} + 8'd1;
			if (held[i]) begin
				activity = 1'b1;
				if (asleep) begin
					// wake press is swallowed
					asleep    = 1'b0;
					woke      = 1'b1;
					hold_d[i] = PARK_COUNT;
				end else if (nxt == {3'b000, cfg.confirm_ticks}) begin
					hold_d[i]  = nxt[6:0];
					armed_d[i] = 1'b1;
					ev[i]      = code_down(2'(i));
					if (code_down(2'(i)) != EV_NONE) begin
						start = 1'b1;
					end
				end else if (nxt == {1'b0, lim}) begin
					hold_d[i]  = nxt[6:0];
					armed_d[i] = 1'b0;
					ev[i]      = code_long(2'(i));
				end else if (nxt > {1'b0, lim}) begin
					hold_d[i] = PARK_COUNT;
				end else begin
					hold_d[i] = nxt[6:0];
				end
			end else begin
				hold_d[i] = '0;
				if (armed_q[i]) begin
					armed_d[i] = 1'b0;
					ev[i]      = code_up(2'(i));
					if (i < 2) begin
						start = 1'b1;
					end
				end
			end
		end
	end

	// beeper: restart on an F1/F2 down or enter/power up event when sound is enabled, then count ticks
	always_comb begin
		act0  = (start && cfg.sound_enable) ? 1'b1 : beep_active_q;
		el0   = (start && cfg.sound_enable) ? 8'd0 : beep_elapsed_q;
		bnext = {1'b0, el0} + 9'd1;
		beep_active_d  = act0;
		beep_elapsed_d = el0;
		if (act0) begin
			beep_active_d  = !(bnext > {1'b0, cfg.beep_ticks});
			beep_elapsed_d = bnext[7:0];
		end
	end

	// pack events in scan order
	always_comb begin
		entry.codes = '0;
		nev = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (ev[i] != EV_NONE) begin
				entry.codes[nev[1:0]] = ev[i];
				nev = nev + 3'd1;
			end
		end
		entry.last_idx     = (nev == 3'd0) ? 2'd0 : 2'(nev - 3'd1);
		entry.beep_on      = beep_active_d;
		entry.wake_screen  = woke;
		entry.key_activity = activity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q         <= '0;
			armed_q        <= '0;
			beep_active_q  <= 1'b0;
			beep_elapsed_q <= '0;
		end else if (push) begin
			hold_q         <= hold_d;
			armed_q        <= armed_d;
			beep_active_q  <= beep_active_d;
			beep_elapsed_q <= beep_elapsed_d;
		end
	end

endmodule

### sv/fkpc_queue.sv
// short first-in first-out queue between front and back
module fkpc_queue #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/fkpc_back.sv
// back part: sends each queued tick out as its items, one per cycle while the event channel is ready
module fkpc_back import fkpc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  q_entry_t      entry,
	input  logic          q_valid,
	output logic          pop,
	fkpc_event_if.source  evt
);

	q_entry_t   cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       is_last, fire;

	assign is_last = (idx_q == cur_q.last_idx);
	assign fire    = evt.valid && evt.ready;
	assign pop     = q_valid && (!busy_q || (fire && is_last));

	assign evt.valid        = busy_q;
	assign evt.event_code   = cur_q.codes[idx_q];
	assign evt.beep_on      = cur_q.beep_on;
	assign evt.wake_screen  = cur_q.wake_screen;
	assign evt.key_activity = cur_q.key_activity;
	assign evt.last         = is_last;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q || (fire && is_last)) begin
			busy_q <= q_valid;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
